// ===== rtl/aarm_pkg.sv =====
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix: shared package
// Transaction types, cell types, pipeline sizing and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int SQRT_STEPS   = 30;
   localparam int DIV_STEPS    = 32;
   localparam int LATENCY      = SQRT_STEPS + DIV_STEPS + 8;
   localparam int CS_DELAY     = SQRT_STEPS + DIV_STEPS + 1 - CORDIC_N;
   localparam int SIDE_LEN     = SQRT_STEPS + 2;

   localparam logic signed [32:0] CORDIC_X0   = 33'sd652032874;
   localparam logic signed [16:0] ANG_FULL    = 17'sd23040;
   localparam logic signed [16:0] ANG_HALF    = 17'sd11520;
   localparam logic signed [16:0] ANG_QUARTER = 17'sd5760;
   localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
   localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
   localparam logic signed [30:0] RND_Q30     = 31'sd536870912;
   localparam logic signed [16:0] RND_Q14     = 17'sd32768;

   typedef struct packed {
      logic signed [15:0] angle_deg;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m_r0c0;
      logic signed [15:0] m_r0c1;
      logic signed [15:0] m_r0c2;
      logic signed [15:0] m_r1c0;
      logic signed [15:0] m_r1c1;
      logic signed [15:0] m_r1c2;
      logic signed [15:0] m_r2c0;
      logic signed [15:0] m_r2c1;
      logic signed [15:0] m_r2c2;
      logic               axis_was_zero;
   } rsp_type;

   typedef struct packed {
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [24:0] z;
      logic               flip;
   } cordic_type;

   typedef struct packed {
      logic [60:0] rem;
      logic [60:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [61:0] rem;
      logic [31:0] quo;
      logic [29:0] divisor;
      logic        neg;
   } div_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [22:0] atan_deg(input logic [4:0] step);
      logic [22:0] v;
      case (step)
         5'd0:    v = 23'd2949120;
         5'd1:    v = 23'd1740967;
         5'd2:    v = 23'd919879;
         5'd3:    v = 23'd466945;
         5'd4:    v = 23'd234379;
         5'd5:    v = 23'd117304;
         5'd6:    v = 23'd58666;
         5'd7:    v = 23'd29335;
         5'd8:    v = 23'd14668;
         5'd9:    v = 23'd7334;
         5'd10:   v = 23'd3667;
         5'd11:   v = 23'd1833;
         5'd12:   v = 23'd917;
         5'd13:   v = 23'd458;
         5'd14:   v = 23'd229;
         5'd15:   v = 23'd115;
         5'd16:   v = 23'd57;
         5'd17:   v = 23'd29;
         5'd18:   v = 23'd14;
         5'd19:   v = 23'd7;
         5'd20:   v = 23'd4;
         5'd21:   v = 23'd2;
         5'd22:   v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/aarm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix: CORDIC cell
// One rotation-mode micro-rotation, registered.
// ----------------------------------------------------------------------------
module aarm_cordic_cell import aarm_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  logic [4:0] step,
   input  cordic_type src,
   output cordic_type dst
);

   cordic_type         cell_ff;
   cordic_type         cell_in;
   logic signed [32:0] x_cur;
   logic signed [32:0] y_cur;
   logic signed [24:0] z_cur;
   logic signed [32:0] xs;
   logic signed [32:0] ys;
   logic signed [24:0] ang;

   always_comb begin
      x_cur   = src.x;
      y_cur   = src.y;
      z_cur   = src.z;
      xs      = x_cur >>> step;
      ys      = y_cur >>> step;
      ang     = signed'({2'b00, atan_deg(step)});
      cell_in = src;
      // rotate positively while the residual angle is not negative
      if (!z_cur[24]) begin
         cell_in.x = x_cur - ys;
         cell_in.y = y_cur + xs;
         cell_in.z = z_cur - ang;
      end else begin
         cell_in.x = x_cur + ys;
         cell_in.y = y_cur - xs;
         cell_in.z = z_cur + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign dst = cell_ff;

endmodule

// ===== rtl/aarm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix: square root cell
// One digit of a bit-pair integer square root, registered.
// ----------------------------------------------------------------------------
module aarm_sqrt_cell import aarm_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  logic [5:0] bit_pos,
   input  sqrt_type   src,
   output sqrt_type   dst
);

   sqrt_type    cell_ff;
   sqrt_type    cell_in;
   logic [60:0] bit_val;
   logic [60:0] trial;

   always_comb begin
      bit_val = 61'd1 << bit_pos;
      trial   = src.root + bit_val;
      cell_in = src;
      if (src.rem >= trial) begin
         cell_in.rem  = src.rem - trial;
         cell_in.root = (src.root >> 1) + bit_val;
      end else begin
         cell_in.root = src.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign dst = cell_ff;

endmodule

// ===== rtl/aarm_div_cell.sv =====
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix: divider cell
// One quotient bit of a restoring division, registered.
// ----------------------------------------------------------------------------
module aarm_div_cell import aarm_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  logic [4:0] shift,
   input  div_type    src,
   output div_type    dst
);

   div_type     cell_ff;
   div_type     cell_in;
   logic [61:0] dshift;

   always_comb begin
      dshift  = 62'(src.divisor) << shift;
      cell_in = src;
      if (src.rem >= dshift) begin
         cell_in.rem = src.rem - dshift;
         cell_in.quo = src.quo | (32'd1 << shift);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign dst = cell_ff;

endmodule

// ===== rtl/axis_angle_rotation_matrix.sv =====
// Throughput: one transaction per cycle while the skid register is empty; every stage is a registered cell.
// Depth is set by the 30-cell square root chain and the 32-cell divider chains in series.
// A one-entry skid register behind the output register holds a result while rsp_stall is high.
// Synchronous active-high reset clears all valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix
// Pipelined Rodrigues rotation matrix: CORDIC sine/cosine, axis normalisation
// by square root and division cells, then Q2.14 matrix assembly.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix import aarm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic [2:0][15:0] mag;
      logic [2:0]       neg;
   } side_type;

   typedef struct packed {
      logic signed [32:0] c;
      logic signed [32:0] s;
   } cs_type;

   // ---------------------------------------------------------------------------
   // Flow control: the whole pipe advances unless the skid register is occupied
   // ---------------------------------------------------------------------------
   logic                en;
   logic [LATENCY-1:0]  vld_ff;
   logic [LATENCY-1:0]  zero_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   logic                skid_valid_ff;
   rsp_type             skid_data_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ---------------------------------------------------------------------------
   // Entry stage: angle reduction, squares, magnitudes
   // ---------------------------------------------------------------------------
   logic signed [16:0] ang_ext;
   logic signed [16:0] ang_wrap;
   logic signed [16:0] ang_fold;
   logic               flip_in;
   logic signed [31:0] sqx_in;
   logic signed [31:0] sqy_in;
   logic signed [31:0] sqz_in;
   cordic_type         cor_start_in;
   side_type           side_start_in;
   logic               zero_in;

   always_comb begin
      ang_ext = {req_data.angle_deg[15], req_data.angle_deg};
      // wrap into (-180, 180] degrees
      if (ang_ext > ANG_HALF) begin
         ang_wrap = ang_ext - ANG_FULL;
      end else if (ang_ext <= -ANG_HALF) begin
         ang_wrap = ang_ext + ANG_FULL;
      end else begin
         ang_wrap = ang_ext;
      end
      // fold into [-90, 90] and negate cosine and sine at the end
      flip_in = 1'b1;
      if (ang_wrap > ANG_QUARTER) begin
         ang_fold = ang_wrap - ANG_HALF;
      end else if (ang_wrap < -ANG_QUARTER) begin
         ang_fold = ang_wrap + ANG_HALF;
      end else begin
         ang_fold = ang_wrap;
         flip_in  = 1'b0;
      end
      cor_start_in.x    = CORDIC_X0;
      cor_start_in.y    = '0;
      cor_start_in.z    = 25'({ang_fold, 10'b0});
      cor_start_in.flip = flip_in;

      sqx_in = req_data.axis_x * req_data.axis_x;
      sqy_in = req_data.axis_y * req_data.axis_y;
      sqz_in = req_data.axis_z * req_data.axis_z;

      side_start_in.mag[0] = req_data.axis_x[15] ? 16'(-req_data.axis_x) : req_data.axis_x;
      side_start_in.mag[1] = req_data.axis_y[15] ? 16'(-req_data.axis_y) : req_data.axis_y;
      side_start_in.mag[2] = req_data.axis_z[15] ? 16'(-req_data.axis_z) : req_data.axis_z;
      side_start_in.neg    = {req_data.axis_z[15], req_data.axis_y[15], req_data.axis_x[15]};

      zero_in = (req_data.axis_x == '0) && (req_data.axis_y == '0) && (req_data.axis_z == '0);
   end

   cordic_type  cor_chain [CORDIC_N+1];
   cordic_type  cor_start_ff;
   side_type    side_ff [SIDE_LEN];
   logic [30:0] sqx_ff;
   logic [30:0] sqy_ff;
   logic [30:0] sqz_ff;
   sqrt_type    sq_start_ff;
   logic [31:0] n2;

   assign n2 = 32'(sqx_ff) + 32'(sqy_ff) + 32'(sqz_ff);
   assign cor_chain[0] = cor_start_ff;

   // ---------------------------------------------------------------------------
   // CORDIC chain: cosine and sine of the folded angle
   // ---------------------------------------------------------------------------
   for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
      aarm_cordic_cell u_cell (
         .clock (clock),
         .en    (en),
         .step  (5'(i)),
         .src   (cor_chain[i]),
         .dst   (cor_chain[i+1])
      );
   end

   cs_type cs_ff [CS_DELAY];
   cs_type cs_start;

   always_comb begin
      cs_start.c = cor_chain[CORDIC_N].flip ? -cor_chain[CORDIC_N].x : cor_chain[CORDIC_N].x;
      cs_start.s = cor_chain[CORDIC_N].flip ? -cor_chain[CORDIC_N].y : cor_chain[CORDIC_N].y;
   end

   // ---------------------------------------------------------------------------
   // Square root chain: S = floor(sqrt(n2 * 2^28))
   // ---------------------------------------------------------------------------
   sqrt_type sq_chain [SQRT_STEPS+1];

   assign sq_chain[0] = sq_start_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      aarm_sqrt_cell u_cell (
         .clock   (clock),
         .en      (en),
         .bit_pos (6'(2 * (SQRT_STEPS - 1 - k))),
         .src     (sq_chain[k]),
         .dst     (sq_chain[k+1])
      );
   end

   // ---------------------------------------------------------------------------
   // Divider chains: unit component = round(|a| * 2^44 / S), one lane per axis
   // ---------------------------------------------------------------------------
   logic [29:0] norm_s;
   div_type     dv [3][DIV_STEPS+1];

   assign norm_s = sq_chain[SQRT_STEPS].root[29:0];

   for (genvar a = 0; a < 3; a++) begin : g_lane
      assign dv[a][0].rem     = 62'({side_ff[SIDE_LEN-1].mag[a], 44'b0}) + 62'(norm_s >> 1);
      assign dv[a][0].quo     = '0;
      assign dv[a][0].divisor = norm_s;
      assign dv[a][0].neg     = side_ff[SIDE_LEN-1].neg[a];
      for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
         aarm_div_cell u_cell (
            .clock (clock),
            .en    (en),
            .shift (5'(DIV_STEPS - 1 - k)),
            .src   (dv[a][k]),
            .dst   (dv[a][k+1])
         );
      end
   end

   // ---------------------------------------------------------------------------
   // Matrix assembly
   // ---------------------------------------------------------------------------
   logic signed [31:0] unit [3];
   cs_type             cs_end;

   assign cs_end = cs_ff[CS_DELAY-1];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         unit[a] = dv[a][DIV_STEPS].neg ? -signed'(dv[a][DIV_STEPS].quo)
                                        : signed'(dv[a][DIV_STEPS].quo);
      end
   end

   // pair order: xx, yy, zz, xy, xz, yz
   logic signed [63:0] puu_ff [6];
   logic signed [64:0] psu_ff [3];
   logic signed [32:0] c65_ff;
   logic signed [32:0] uu_ff [6];
   logic signed [32:0] su66_ff [3];
   logic signed [32:0] omc_ff;
   logic signed [32:0] c66_ff;
   logic signed [65:0] pou_ff [6];
   logic signed [32:0] su67_ff [3];
   logic signed [32:0] c67_ff;
   logic signed [33:0] ou_ff [6];
   logic signed [32:0] su68_ff [3];
   logic signed [32:0] c68_ff;
   logic signed [34:0] e_ff [9];
   rsp_type            res_ff;
   rsp_type            res_in;

   function automatic logic signed [15:0] sat_q14(input logic signed [34:0] e);
      logic signed [34:0] t;
      logic signed [18:0] r;
      t = e + 35'(RND_Q14);
      r = 19'(t >>> 16);
      if (r > 19'sd32767) begin
         return 16'sh7fff;
      end else if (r < -19'sd32768) begin
         return 16'sh8000;
      end
      return 16'(r);
   endfunction

   always_comb begin
      res_in.m_r0c0        = sat_q14(e_ff[0]);
      res_in.m_r0c1        = sat_q14(e_ff[1]);
      res_in.m_r0c2        = sat_q14(e_ff[2]);
      res_in.m_r1c0        = sat_q14(e_ff[3]);
      res_in.m_r1c1        = sat_q14(e_ff[4]);
      res_in.m_r1c2        = sat_q14(e_ff[5]);
      res_in.m_r2c0        = sat_q14(e_ff[6]);
      res_in.m_r2c1        = sat_q14(e_ff[7]);
      res_in.m_r2c2        = sat_q14(e_ff[8]);
      res_in.axis_was_zero = 1'b0;
      // zero axis: substitute the identity and ignore the angle
      if (zero_ff[LATENCY-2]) begin
         res_in        = '0;
         res_in.m_r0c0 = ONE_Q14;
         res_in.m_r1c1 = ONE_Q14;
         res_in.m_r2c2 = ONE_Q14;
         res_in.axis_was_zero = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Payload registers: advance on en, no reset
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (en) begin
         cor_start_ff <= cor_start_in;
         side_ff[0]   <= side_start_in;
         for (int j = 1; j < SIDE_LEN; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
         sqx_ff <= sqx_in[30:0];
         sqy_ff <= sqy_in[30:0];
         sqz_ff <= sqz_in[30:0];
         sq_start_ff.rem  <= {1'b0, n2, 28'b0};
         sq_start_ff.root <= '0;

         cs_ff[0] <= cs_start;
         for (int j = 1; j < CS_DELAY; j++) begin
            cs_ff[j] <= cs_ff[j-1];
         end

         // raw products
         puu_ff[0] <= unit[0] * unit[0];
         puu_ff[1] <= unit[1] * unit[1];
         puu_ff[2] <= unit[2] * unit[2];
         puu_ff[3] <= unit[0] * unit[1];
         puu_ff[4] <= unit[0] * unit[2];
         puu_ff[5] <= unit[1] * unit[2];
         for (int a = 0; a < 3; a++) begin
            psu_ff[a] <= cs_end.s * unit[a];
         end
         c65_ff <= cs_end.c;

         // round back to Q.30
         for (int p = 0; p < 6; p++) begin
            uu_ff[p] <= 33'((puu_ff[p] + 64'(RND_Q30)) >>> 30);
         end
         for (int a = 0; a < 3; a++) begin
            su66_ff[a] <= 33'((psu_ff[a] + 65'(RND_Q30)) >>> 30);
         end
         omc_ff <= ONE_Q30 - c65_ff;
         c66_ff <= c65_ff;

         // scale by one minus cosine
         for (int p = 0; p < 6; p++) begin
            pou_ff[p] <= omc_ff * uu_ff[p];
         end
         su67_ff <= su66_ff;
         c67_ff  <= c66_ff;

         for (int p = 0; p < 6; p++) begin
            ou_ff[p] <= 34'((pou_ff[p] + 66'(RND_Q30)) >>> 30);
         end
         su68_ff <= su67_ff;
         c68_ff  <= c67_ff;

         // Rodrigues entries
         e_ff[0] <= 35'(c68_ff) + 35'(ou_ff[0]);
         e_ff[4] <= 35'(c68_ff) + 35'(ou_ff[1]);
         e_ff[8] <= 35'(c68_ff) + 35'(ou_ff[2]);
         e_ff[1] <= 35'(ou_ff[3]) - 35'(su68_ff[2]);
         e_ff[3] <= 35'(ou_ff[3]) + 35'(su68_ff[2]);
         e_ff[2] <= 35'(ou_ff[4]) + 35'(su68_ff[1]);
         e_ff[6] <= 35'(ou_ff[4]) - 35'(su68_ff[1]);
         e_ff[5] <= 35'(ou_ff[5]) - 35'(su68_ff[0]);
         e_ff[7] <= 35'(ou_ff[5]) + 35'(su68_ff[0]);

         res_ff <= res_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Control registers: valid and zero-axis flags travel with the transaction
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         zero_ff <= '0;
      end else if (en) begin
         vld_ff  <= {vld_ff[LATENCY-2:0], req_valid};
         zero_ff <= {zero_ff[LATENCY-2:0], zero_in};
      end
   end

   // ---------------------------------------------------------------------------
   // Output register with skid: catch the pipe's result while the output stalls
   // ---------------------------------------------------------------------------
   logic pipe_out;

   assign pipe_out = en && vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && rsp_stall) begin
         if (pipe_out) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pipe_out;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && rsp_stall) begin
         if (pipe_out) begin
            skid_data_ff <= res_ff;
         end
      end else if (skid_valid_ff) begin
         rsp_data_ff <= skid_data_ff;
      end else if (pipe_out) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid occupied while output register empty");

   a_pipe_held: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> vld_ff == $past(vld_ff))
      else $error("pipeline advanced while skid occupied");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && pipe_out |=> skid_valid_ff)
      else $error("result lost while output stalled");

   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.axis_was_zero |->
         rsp_data_ff.m_r1c1 == ONE_Q14 && rsp_data_ff.m_r0c1 == '0 &&
         rsp_data_ff.m_r2c2 == ONE_Q14)
      else $error("zero axis did not give the identity");

endmodule
